// File: sv/art_pkg.sv
`default_nettype none

package art_pkg;

   // Field widths of the channels.
   localparam int OP_W        = 2;
   localparam int SEQ_W       = 16;
   localparam int KIND_W      = 4;
   localparam int SLOT_W      = 4;
   localparam int RETRY_W     = 8;
   localparam int AGE_W       = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Table depth default.
   localparam int SLOTS_DEFAULT = 16;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
   localparam logic [OP_W-1:0] OP_CONFIRM = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK    = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_ACCEPTED   = 4'd0;
   localparam logic [KIND_W-1:0] KIND_FULL       = 4'd1;
   localparam logic [KIND_W-1:0] KIND_CONFIRMED  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_UNMATCHED  = 4'd3;
   localparam logic [KIND_W-1:0] KIND_RETRANSMIT = 4'd4;
   localparam logic [KIND_W-1:0] KIND_BYE_DONE   = 4'd5;
   localparam logic [KIND_W-1:0] KIND_BYE_FAILED = 4'd6;
   localparam logic [KIND_W-1:0] KIND_SCAN_DONE  = 4'd7;
   localparam logic [KIND_W-1:0] KIND_HALTED     = 4'd8;

   // Configuration register indexes and reset values.
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RETRIES   = 4'd1;
   localparam logic [AGE_W-1:0]       TIMEOUT_RESET     = 16'd250;
   localparam logic [RETRY_W-1:0]     MAX_RETRIES_RESET = 8'd3;

   // One result as the sequencer produces it.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SLOT_W-1:0]  slot;
      logic [SEQ_W-1:0]   seq_out;
      logic [RETRY_W-1:0] retry_count;
      logic               last;
   } result_type;

endpackage

`default_nettype wire

// File: sv/art_if.sv
`default_nettype none

interface art_req_if;
   import art_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [SEQ_W-1:0]  seq;
   logic              is_bye;
   modport source (output valid, op, seq, is_bye, input ready);
   modport sink   (input valid, op, seq, is_bye, output ready);
endinterface

interface art_rsp_if;
   import art_pkg::*;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [SLOT_W-1:0]  slot;
   logic [SEQ_W-1:0]   seq_out;
   logic [RETRY_W-1:0] retry_count;
   logic               last;
   modport source (output valid, kind, slot, seq_out, retry_count, last, input ready);
   modport sink   (input valid, kind, slot, seq_out, retry_count, last, output ready);
endinterface

interface art_csr_if;
   import art_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/ack_retransmit_tracker.sv
// Channel   Port      Direction  Carries
// request   req_bus   in         op, seq, is_bye
// result    rsp_bus   out        kind, slot, seq_out, retry_count, last
// config    csr_bus   in         index, data (ready whenever reset is low)
//
// A send, confirm or tick walks the slots one per cycle, while no result stall
// holds it, through a single compare/increment unit, and a closing result
// follows when the walk reaches the end. A halted block answers with a single
// halted result and does not walk the slots.
// Reset is synchronous and clears the control state and the slot flags.
// A result waiting in the output register stalls the walk only when another
// result must be produced.
`default_nettype none

module ack_retransmit_tracker
   import art_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   art_req_if.sink   req_bus,
   art_rsp_if.source rsp_bus,
   art_csr_if.sink   csr_bus
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_END   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [OP_W-1:0]    op_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic               bye_ff;
   logic               halted_ff, halted_in;
   logic [AGE_W-1:0]   timeout_ff;
   logic [RETRY_W-1:0] max_retries_ff;
   logic [SLOTS-1:0]   pending_ff, pending_in;
   logic [SLOTS-1:0]   acked_ff, acked_in;
   logic [SLOTS-1:0]   byem_ff, byem_in;

   // Slot table payload; entries are read on every walk but used only after a send has written them.
   logic [SEQ_W-1:0]   seq_mem_ff [SLOTS];
   logic [AGE_W-1:0]   age_mem_ff [SLOTS];
   logic [RETRY_W-1:0] ret_mem_ff [SLOTS];
   logic [SEQ_W-1:0]   rd_seq_ff;
   logic [AGE_W-1:0]   rd_age_ff;
   logic [RETRY_W-1:0] rd_ret_ff;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   logic               seq_we, age_we, ret_we;
   logic [AGE_W-1:0]   age_wdata;
   logic [RETRY_W-1:0] ret_wdata;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff;
   logic               emit;
   result_type         res;
   logic               free;
   logic               accept;

   logic [IW+SLOT_W-1:0] slot_wide;
   logic [SLOT_W-1:0]    cur_slot;
   logic                 cur_pend, cur_acked, cur_bye;
   logic [AGE_W-1:0]     age_inc;
   logic [RETRY_W-1:0]   ret_inc;

   // Neither input channel takes a transaction while reset is held.
   assign req_bus.ready = (state_ff == ST_IDLE) && !reset;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = !reset;
   assign free          = !rsp_valid_ff || rsp_bus.ready;

   assign slot_wide = {{SLOT_W{1'b0}}, idx_ff};
   assign cur_slot  = slot_wide[SLOT_W-1:0];
   assign cur_pend  = pending_ff[idx_ff];
   assign cur_acked = acked_ff[idx_ff];
   assign cur_bye   = byem_ff[idx_ff];
   assign ret_inc   = rd_ret_ff + RETRY_W'(1);

   // The shared unit: aging a pending entry saturates at the top of the range.
   always_comb begin
      if (cur_pend && (rd_age_ff != {AGE_W{1'b1}})) begin
         age_inc = rd_age_ff + AGE_W'(1);
      end else begin
         age_inc = rd_age_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      halted_in  = halted_ff;
      pending_in = pending_ff;
      acked_in   = acked_ff;
      byem_in    = byem_ff;
      rd_en      = 1'b0;
      rd_addr    = idx_ff;
      seq_we     = 1'b0;
      age_we     = 1'b0;
      ret_we     = 1'b0;
      age_wdata  = '0;
      ret_wdata  = '0;
      emit       = 1'b0;
      res        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (halted_ff) begin
               res.kind = KIND_HALTED;
               res.last = 1'b1;
               if (free) begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (op_ff == OP_UNUSED) begin
               state_in = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            logic hit;
            logic stop;
            hit  = 1'b0;
            stop = 1'b0;
            res.slot = cur_slot;
            unique case (op_ff)
               OP_SEND: begin
                  hit             = !cur_pend;
                  stop            = hit;
                  res.kind        = KIND_ACCEPTED;
                  res.seq_out     = seq_ff;
                  res.last        = 1'b1;
               end
               OP_CONFIRM: begin
                  hit             = cur_pend && (rd_seq_ff == seq_ff);
                  stop            = hit;
                  res.kind        = KIND_CONFIRMED;
                  res.seq_out     = seq_ff;
                  res.retry_count = rd_ret_ff;
                  res.last        = 1'b1;
               end
               OP_TICK: begin
                  res.seq_out     = rd_seq_ff;
                  res.retry_count = rd_ret_ff;
                  if (cur_acked && cur_bye) begin
                     hit      = 1'b1;
                     stop     = 1'b1;
                     res.kind = KIND_BYE_DONE;
                     res.last = 1'b1;
                  end else if (cur_pend && cur_bye && (rd_ret_ff >= max_retries_ff)) begin
                     hit      = 1'b1;
                     stop     = 1'b1;
                     res.kind = KIND_BYE_FAILED;
                     res.last = 1'b1;
                  end else if (cur_pend && (age_inc >= timeout_ff)
                               && (rd_ret_ff < max_retries_ff)) begin
                     hit             = 1'b1;
                     res.kind        = KIND_RETRANSMIT;
                     res.retry_count = ret_inc;
                  end
               end
               default: begin
                  stop = 1'b1;
               end
            endcase

            if (!hit || free) begin
               emit = hit;
               if (stop) begin
                  state_in = ST_IDLE;
                  if (op_ff == OP_SEND && hit) begin
                     pending_in[idx_ff] = 1'b1;
                     acked_in[idx_ff]   = 1'b0;
                     byem_in[idx_ff]    = bye_ff;
                     seq_we             = 1'b1;
                     age_we             = 1'b1;
                     ret_we             = 1'b1;
                  end else if (op_ff == OP_CONFIRM && hit) begin
                     pending_in[idx_ff] = 1'b0;
                     acked_in[idx_ff]   = 1'b1;
                  end else if (op_ff == OP_TICK && hit) begin
                     halted_in = 1'b1;
                  end
               end else begin
                  if (op_ff == OP_TICK && cur_pend) begin
                     age_we = 1'b1;
                     if (hit) begin
                        ret_we    = 1'b1;
                        ret_wdata = ret_inc;
                     end else begin
                        age_wdata = age_inc;
                     end
                  end
                  if (idx_ff == LAST_IDX) begin
                     state_in = ST_END;
                  end else begin
                     idx_in   = idx_ff + IW'(1);
                     rd_en    = 1'b1;
                     rd_addr  = idx_in;
                  end
               end
            end
         end
         ST_END: begin
            res.last = 1'b1;
            if (op_ff == OP_SEND) begin
               res.kind    = KIND_FULL;
               res.seq_out = seq_ff;
            end else if (op_ff == OP_CONFIRM) begin
               res.kind    = KIND_UNMATCHED;
               res.seq_out = seq_ff;
            end else begin
               res.kind    = KIND_SCAN_DONE;
            end
            if (free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         halted_ff      <= 1'b0;
         pending_ff     <= '0;
         acked_ff       <= '0;
         byem_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         timeout_ff     <= TIMEOUT_RESET;
         max_retries_ff <= MAX_RETRIES_RESET;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         halted_ff    <= halted_in;
         pending_ff   <= pending_in;
         acked_ff     <= acked_in;
         byem_ff      <= byem_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == CSR_TIMEOUT_TICKS) begin
               timeout_ff <= csr_bus.data;
            end else if (csr_bus.index == CSR_MAX_RETRIES) begin
               max_retries_ff <= csr_bus.data[RETRY_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_bus.op;
         seq_ff <= req_bus.seq;
         bye_ff <= req_bus.is_bye;
      end
      if (emit) begin
         rsp_ff <= res;
      end
   end

   // Slot memories: one write at the current slot, one registered read.
   always_ff @(posedge clock) begin
      if (seq_we) begin
         seq_mem_ff[idx_ff] <= seq_ff;
      end
      if (age_we) begin
         age_mem_ff[idx_ff] <= age_wdata;
      end
      if (ret_we) begin
         ret_mem_ff[idx_ff] <= ret_wdata;
      end
      if (rd_en) begin
         rd_seq_ff <= seq_mem_ff[rd_addr];
         rd_age_ff <= age_mem_ff[rd_addr];
         rd_ret_ff <= ret_mem_ff[rd_addr];
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.kind        = rsp_ff.kind;
   assign rsp_bus.slot        = rsp_ff.slot;
   assign rsp_bus.seq_out     = rsp_ff.seq_out;
   assign rsp_bus.retry_count = rsp_ff.retry_count;
   assign rsp_bus.last        = rsp_ff.last;

endmodule

`default_nettype wire

// File: tb/sv/ack_table_checker.sv
`default_nettype none

module ack_table_checker
   import art_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   art_req_if        req_mon,
   art_rsp_if        rsp_mon,
   art_csr_if        csr_mon,
   output int        error_count,
   output int        results_waiting,
   output int        results_checked,
   output int        free_slots
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow of the retransmit table and its settings.
   logic [SLOTS-1:0]   in_flight;
   logic [SLOTS-1:0]   was_confirmed;
   logic [SLOTS-1:0]   closing_msg;
   logic [SEQ_W-1:0]   slot_seq   [SLOTS];
   logic [AGE_W-1:0]   slot_age   [SLOTS];
   logic [RETRY_W-1:0] slot_tries [SLOTS];
   logic               stopped;
   logic [AGE_W-1:0]   ack_timeout;
   logic [RETRY_W-1:0] tries_allowed;

   result_type due_results [$];

   initial begin
      error_count     = 0;
      results_waiting = 0;
      results_checked = 0;
      free_slots      = SLOTS;
   end

   function automatic void add_due(input logic [KIND_W-1:0] kind, input int slot,
                                   input logic [SEQ_W-1:0] seq,
                                   input logic [RETRY_W-1:0] tries, input logic last);
      result_type r;
      r.kind        = kind;
      r.slot        = SLOT_W'(slot);
      r.seq_out     = seq;
      r.retry_count = tries;
      r.last        = last;
      due_results.push_back(r);
   endfunction

   // Updates the shadow table for one request and queues the results it causes.
   function automatic void apply_request(input logic [OP_W-1:0] op,
                                         input logic [SEQ_W-1:0] seq, input logic bye);
      int i;
      bit hit;
      hit = 1'b0;
      if (stopped) begin
         add_due(KIND_HALTED, 0, '0, '0, 1'b1);
         return;
      end
      case (op)
         OP_SEND: begin
            for (i = 0; i < SLOTS; i++) begin
               if (!hit && !in_flight[i]) begin
                  hit              = 1'b1;
                  in_flight[i]     = 1'b1;
                  was_confirmed[i] = 1'b0;
                  closing_msg[i]   = bye;
                  slot_seq[i]      = seq;
                  slot_age[i]      = '0;
                  slot_tries[i]    = '0;
                  add_due(KIND_ACCEPTED, i, seq, '0, 1'b1);
               end
            end
            if (!hit)
               add_due(KIND_FULL, 0, seq, '0, 1'b1);
         end
         OP_CONFIRM: begin
            for (i = 0; i < SLOTS; i++) begin
               if (!hit && in_flight[i] && slot_seq[i] == seq) begin
                  hit              = 1'b1;
                  in_flight[i]     = 1'b0;
                  was_confirmed[i] = 1'b1;
                  add_due(KIND_CONFIRMED, i, seq, slot_tries[i], 1'b1);
               end
            end
            if (!hit)
               add_due(KIND_UNMATCHED, 0, seq, '0, 1'b1);
         end
         OP_TICK: begin
            for (i = 0; i < SLOTS; i++)
               if (in_flight[i] && slot_age[i] != '1)
                  slot_age[i] = slot_age[i] + 1'b1;
            // The walk stops at the first bye that is either confirmed or out of retries.
            for (i = 0; i < SLOTS; i++) begin
               if (hit) begin
               end else if (was_confirmed[i] && closing_msg[i]) begin
                  hit     = 1'b1;
                  stopped = 1'b1;
                  add_due(KIND_BYE_DONE, i, slot_seq[i], slot_tries[i], 1'b1);
               end else if (in_flight[i] && closing_msg[i] &&
                            slot_tries[i] >= tries_allowed) begin
                  hit     = 1'b1;
                  stopped = 1'b1;
                  add_due(KIND_BYE_FAILED, i, slot_seq[i], slot_tries[i], 1'b1);
               end else if (in_flight[i] && slot_age[i] >= ack_timeout &&
                            slot_tries[i] < tries_allowed) begin
                  slot_tries[i] = slot_tries[i] + 1'b1;
                  slot_age[i]   = '0;
                  add_due(KIND_RETRANSMIT, i, slot_seq[i], slot_tries[i], 1'b0);
               end
            end
            if (!hit)
               add_due(KIND_SCAN_DONE, 0, '0, '0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      int i;
      if (reset) begin
         in_flight     = '0;
         was_confirmed = '0;
         closing_msg   = '0;
         stopped       = 1'b0;
         ack_timeout   = TIMEOUT_RESET;
         tries_allowed = MAX_RETRIES_RESET;
         for (i = 0; i < SLOTS; i++) begin
            slot_seq[i]   = '0;
            slot_age[i]   = '0;
            slot_tries[i] = '0;
         end
         due_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.kind        = rsp_mon.kind;
            got.slot        = rsp_mon.slot;
            got.seq_out     = rsp_mon.seq_out;
            got.retry_count = rsp_mon.retry_count;
            got.last        = rsp_mon.last;
            results_checked++;
            if (due_results.size() == 0) begin
               error_count++;
               $display("%0t: result with none expected: kind %0d slot %0d seq %h retries %0d last %0b",
                        $time, got.kind, got.slot, got.seq_out, got.retry_count, got.last);
            end else begin
               want = due_results.pop_front();
               if (got.kind !== want.kind || got.slot !== want.slot ||
                   got.seq_out !== want.seq_out || got.retry_count !== want.retry_count ||
                   got.last !== want.last) begin
                  error_count++;
                  $display("%0t: expected kind %0d slot %0d seq %h retries %0d last %0b",
                           $time, want.kind, want.slot, want.seq_out, want.retry_count,
                           want.last);
                  $display("%0t:   actual kind %0d slot %0d seq %h retries %0d last %0b",
                           $time, got.kind, got.slot, got.seq_out, got.retry_count, got.last);
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_TIMEOUT_TICKS)
               ack_timeout = csr_mon.data[AGE_W-1:0];
            else if (csr_mon.index == CSR_MAX_RETRIES)
               tries_allowed = csr_mon.data[RETRY_W-1:0];
         end
         if (req_mon.valid && req_mon.ready)
            apply_request(req_mon.op, req_mon.seq, req_mon.is_bye);
      end
      results_waiting = due_results.size();
      free_slots      = SLOTS - $countones(in_flight);
   end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import art_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 3;
   localparam int DRAIN_CYCLES   = 24;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 48;

   // An index outside the register map; the block must ignore writes to it.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 4'hE;

   typedef enum int {END_BYE_DONE, END_NO_BUDGET, END_RETRIES_USED} ending_type;

   logic clock;
   logic reset;

   art_req_if req_bus ();
   art_rsp_if rsp_bus ();
   art_csr_if csr_bus ();

   int error_count;
   int results_waiting;
   int results_checked;
   int free_slots;

   ack_retransmit_tracker DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   ack_table_checker table_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_mon         (csr_bus),
      .error_count     (error_count),
      .results_waiting (results_waiting),
      .results_checked (results_checked),
      .free_slots      (free_slots)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Sequence numbers sent and not yet confirmed by this side. It may hold stale
   // entries, but never fewer copies of a number than the table holds.
   logic [SEQ_W-1:0] unconfirmed [$];

   int  op_count [4];
   int  requests_sent = 0;
   int  settings_used = 0;
   bit  req_fast = 1'b0;
   int  quiet_cycles = 0;

   task automatic drive_request(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                                input logic bye);
      int gap;
      gap = req_fast ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.op     <= op;
      req_bus.seq    <= seq;
      req_bus.is_bye <= bye;
      do @(posedge clock); while (!req_bus.ready);
      op_count[op]++;
      requests_sent++;
      if (requests_sent % 16 == 0)
         req_fast = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_dgram(input logic [SEQ_W-1:0] seq, input logic bye);
      unconfirmed.push_back(seq);
      drive_request(OP_SEND, seq, bye);
   endtask

   task automatic confirm_dgram(input logic [SEQ_W-1:0] seq, input logic bye);
      int k;
      bit gone;
      gone = 1'b0;
      for (k = 0; k < unconfirmed.size(); k++) begin
         if (!gone && unconfirmed[k] == seq) begin
            unconfirmed.delete(k);
            gone = 1'b1;
         end
      end
      drive_request(OP_CONFIRM, seq, bye);
   endtask

   // Waits until every predicted result has come out and the walk has surely ended.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (results_waiting != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic configure(input int ticks, input int tries);
      logic [CSR_DATA_W-1:0] data;
      wait_idle();
      write_reg(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      write_reg(CSR_TIMEOUT_TICKS, CSR_DATA_W'(ticks));
      // Upper data bits are junk; the register keeps only its own width.
      data = CSR_DATA_W'($urandom);
      data[RETRY_W-1:0] = RETRY_W'(tries);
      write_reg(CSR_MAX_RETRIES, data);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random_phase(input int ticks, input int tries, input int send_pct);
      int n;
      int pick;
      int style;
      logic [SEQ_W-1:0] seq;
      configure(ticks, tries);
      for (n = 0; n < PHASE_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         seq  = $urandom;
         if (pick < send_pct) begin
            style = $urandom_range(0, 19);
            if (style == 0)
               seq = '0;
            else if (style == 1)
               seq = '1;
            else if (style < 4 && unconfirmed.size() != 0)
               seq = unconfirmed[$urandom_range(0, unconfirmed.size() - 1)];
            send_dgram(seq, 1'b0);
         end else if (pick < send_pct + 25) begin
            if ($urandom_range(0, 9) < 8 && unconfirmed.size() != 0)
               seq = unconfirmed[$urandom_range(0, unconfirmed.size() - 1)];
            confirm_dgram(seq, $urandom_range(0, 1));
         end else if (pick < 96) begin
            drive_request(OP_TICK, seq, $urandom_range(0, 1));
         end else begin
            drive_request(OP_UNUSED, seq, $urandom_range(0, 1));
         end
      end
   endtask

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: random stalls, fast stretches, and two long hold-offs that
   // back the table up into the request channel.
   initial begin
      int stall;
      int taken;
      bit rsp_fast;
      taken    = 0;
      rsp_fast = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == 40 || taken == 220) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = rsp_fast ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         taken++;
         if (taken % 16 == 0)
            rsp_fast = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      logic [SEQ_W-1:0] bye_seq;
      bit clash;
      ending_type ending;
      string ending_text;
      int k;

      foreach (op_count[k]) op_count[k] = 0;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.op     <= OP_SEND;
      req_bus.seq    <= '0;
      req_bus.is_bye <= 1'b0;
      csr_bus.valid  <= 1'b0;
      csr_bus.index  <= CSR_TIMEOUT_TICKS;
      csr_bus.data   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings. A confirmed bye is made harmless
      // by reusing its slot before any tick reaches it.
      send_dgram(16'hFFFF, 1'b1);
      confirm_dgram(16'hFFFF, 1'b0);
      send_dgram(16'h0000, 1'b0);
      send_dgram(16'h1234, 1'b0);
      send_dgram(16'h1234, 1'b0);
      confirm_dgram(16'h1234, 1'b0);
      confirm_dgram(16'hABCD, 1'b1);
      drive_request(OP_UNUSED, 16'hFFFF, 1'b1);
      drive_request(OP_TICK, 16'h8001, 1'b1);

      // Zero timeout: both entries go out on every tick until the budget is spent.
      configure(0, 2);
      drive_request(OP_TICK, 16'h0000, 1'b0);
      drive_request(OP_TICK, 16'h7FFE, 1'b1);
      drive_request(OP_TICK, 16'hFFFF, 1'b0);
      confirm_dgram(16'h0000, 1'b0);

      run_random_phase(1, 255, 60);
      run_random_phase(3, 1, 45);
      run_random_phase(2, 0, 50);
      run_random_phase(65535, 255, 40);
      run_random_phase(0, 5, 55);
      run_random_phase(4, 3, 60);

      // Closing: a bye halts the block for good, so only one way of ending fits
      // in a run. First make sure the bye finds a free slot.
      wait_idle();
      while (free_slots == 0 && unconfirmed.size() != 0) begin
         confirm_dgram(unconfirmed[0], 1'b0);
         wait_idle();
      end
      bye_seq = $urandom;
      clash   = 1'b1;
      while (clash) begin
         clash = 1'b0;
         foreach (unconfirmed[k])
            if (unconfirmed[k] == bye_seq) clash = 1'b1;
         if (clash) bye_seq = $urandom;
      end
      ending = ending_type'($urandom_range(0, 2));
      case (ending)
         END_BYE_DONE: begin
            ending_text = "a confirmed bye";
            configure($urandom_range(0, 65535), $urandom_range(0, 255));
            send_dgram(bye_seq, 1'b1);
            confirm_dgram(bye_seq, 1'b0);
            drive_request(OP_TICK, $urandom, 1'b0);
         end
         END_NO_BUDGET: begin
            ending_text = "a bye with no retry budget";
            configure($urandom_range(0, 65535), 0);
            send_dgram(bye_seq, 1'b1);
            drive_request(OP_TICK, $urandom, 1'b1);
         end
         default: begin
            ending_text = "a bye whose retries ran out";
            configure(1, 2);
            send_dgram(bye_seq, 1'b1);
            for (k = 0; k < 3; k++)
               drive_request(OP_TICK, $urandom, $urandom_range(0, 1));
         end
      endcase
      // Once halted, every request answers with a single halted result.
      send_dgram($urandom, 1'b1);
      drive_request(OP_CONFIRM, bye_seq, $urandom_range(0, 1));
      drive_request(OP_TICK, $urandom, $urandom_range(0, 1));
      drive_request(OP_UNUSED, $urandom, $urandom_range(0, 1));
      send_dgram($urandom, 1'b0);
      wait_idle();

      $display("Drove %0d requests (%0d sends, %0d confirmations, %0d ticks, %0d unused code)",
               requests_sent, op_count[OP_SEND], op_count[OP_CONFIRM], op_count[OP_TICK],
               op_count[OP_UNUSED]);
      $display("under %0d register settings; %0d results compared; halted by %s.",
               settings_used, results_checked, ending_text);
      if (error_count == 0 && results_waiting == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
sv/art_pkg.sv
sv/art_if.sv
sv/ack_retransmit_tracker.sv
tb/sv/ack_table_checker.sv
tb/sv/testbench.sv
